// ===== rtl/circ_pkg.sv =====
package circ_pkg;

    // default coordinate width (signed, fixed point)
    localparam int COORD_WIDTH_DEF = 16;

    // collinearity tolerance register
    localparam int              TOL_WIDTH = 34;
    localparam logic [33:0]     TOL_RESET = 34'd1;

    // result widths
    localparam int CENTRE_WIDTH = 32;
    localparam int RSQ_WIDTH    = 63;
    localparam int RLEN_WIDTH   = 32;
    localparam int RSQ_SUM_W    = 65;

    // radius path limits: centre magnitude below 2^40, difference below 2^32
    localparam int SMALL_BITS = 40;
    localparam int DIFF_BITS  = 32;
    localparam int DIFF_WIDTH = 43;

    // root pipeline: one result bit per stage
    localparam int ROOT_STEPS = 32;

endpackage

// ===== rtl/circumcircle_from_three_points_unit.sv =====
// Channel   | valid    | stall    | word
// ----------+----------+----------+--------------------------------------------
// input     | i_valid  | o_stall  | i_point_{a,b,c}_{x,y}
// result    | o_valid  | i_stall  | o_ok o_saturated o_centre_{x,y} o_radius_*
// config    | i_cfg_wr_en (no stall) | i_cfg_wr_data (collinear tolerance)
//
// One word accepted per cycle while o_stall is low. The depth is set by the
// restoring divider (one quotient bit per stage) and the square root (one bit
// per stage).
// Reset clears the valid pipe and sets the tolerance to 1; data registers keep
// no reset. A stalled result freezes the whole pipe, so nothing is lost.
module circumcircle_from_three_points_unit #(
    parameter int COORD_WIDTH = circ_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [circ_pkg::TOL_WIDTH-1:0]        i_cfg_wr_data,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [COORD_WIDTH-1:0]         i_point_a_x,
    input  logic signed [COORD_WIDTH-1:0]         i_point_a_y,
    input  logic signed [COORD_WIDTH-1:0]         i_point_b_x,
    input  logic signed [COORD_WIDTH-1:0]         i_point_b_y,
    input  logic signed [COORD_WIDTH-1:0]         i_point_c_x,
    input  logic signed [COORD_WIDTH-1:0]         i_point_c_y,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_ok,
    output logic                                  o_saturated,
    output logic signed [circ_pkg::CENTRE_WIDTH-1:0] o_centre_x,
    output logic signed [circ_pkg::CENTRE_WIDTH-1:0] o_centre_y,
    output logic [circ_pkg::RSQ_WIDTH-1:0]        o_radius_squared,
    output logic [circ_pkg::RLEN_WIDTH-1:0]       o_radius_length
);

    localparam int W    = COORD_WIDTH;
    localparam int DFW  = W + 1;          // point differences
    localparam int SQW  = 2 * W;          // coordinate squares
    localparam int PW   = 2 * W + 2;      // det products, A2, B2
    localparam int DTW  = 2 * W + 3;      // determinant
    localparam int ABW  = 2 * W + 2;      // |det|
    localparam int DNW  = 2 * W + 3;      // divisor 2*|det|
    localparam int MW   = 3 * W + 3;      // numerator products
    localparam int NW   = 3 * W + 4;      // numerator and quotient
    localparam int QXW  = (NW > circ_pkg::SMALL_BITS + 1) ? NW : circ_pkg::SMALL_BITS + 1;
    localparam int CW   = (ABW > circ_pkg::TOL_WIDTH) ? ABW : circ_pkg::TOL_WIDTH;
    localparam int XW   = circ_pkg::DIFF_WIDTH;
    localparam int CTW  = circ_pkg::CENTRE_WIDTH;
    localparam int RQW  = circ_pkg::RSQ_WIDTH;
    localparam int RS   = circ_pkg::ROOT_STEPS;
    localparam int NV   = NW + 42;        // total register stages

    typedef struct packed {
        logic                  ok;
        logic                  qxn;
        logic                  qyn;
        logic [W-1:0]          ax;
        logic [W-1:0]          ay;
        logic [DNW-1:0]        den;
        logic [DNW+NW-1:0]     rx;   // {remainder, numerator/quotient}
        logic [DNW+NW-1:0]     ry;
    } t_div;

    typedef struct packed {
        logic                  ok;
        logic                  sat;
        logic [CTW-1:0]        cx;
        logic [CTW-1:0]        cy;
        logic [RQW-1:0]        rsq;
        logic [63:0]           rem;
        logic [63:0]           res;
    } t_root;

    // global advance: the pipe moves unless a finished word is held
    logic          en;
    logic [NV-1:0] r_vld;

    assign en      = !(r_vld[NV-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[NV-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NV-2:0], i_valid};
        end
    end

    // tolerance register
    logic [circ_pkg::TOL_WIDTH-1:0] r_tol;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= circ_pkg::TOL_RESET;
        end else if (i_cfg_wr_en) begin
            r_tol <= i_cfg_wr_data;
        end
    end

    // stage 1: edge differences and squares
    logic signed [DFW-1:0] r1_abx, r1_aby, r1_bcx, r1_bcy;
    logic signed [SQW-1:0] r1_ax2, r1_ay2, r1_bx2, r1_by2, r1_cx2, r1_cy2;
    logic [W-1:0]          r1_ax, r1_ay;
    logic signed [DFW-1:0] n1_abx, n1_aby, n1_bcx, n1_bcy;
    logic signed [SQW-1:0] n1_ax2, n1_ay2, n1_bx2, n1_by2, n1_cx2, n1_cy2;

    assign n1_abx = DFW'(i_point_a_x) - DFW'(i_point_b_x);
    assign n1_aby = DFW'(i_point_a_y) - DFW'(i_point_b_y);
    assign n1_bcx = DFW'(i_point_b_x) - DFW'(i_point_c_x);
    assign n1_bcy = DFW'(i_point_b_y) - DFW'(i_point_c_y);
    assign n1_ax2 = i_point_a_x * i_point_a_x;
    assign n1_ay2 = i_point_a_y * i_point_a_y;
    assign n1_bx2 = i_point_b_x * i_point_b_x;
    assign n1_by2 = i_point_b_y * i_point_b_y;
    assign n1_cx2 = i_point_c_x * i_point_c_x;
    assign n1_cy2 = i_point_c_y * i_point_c_y;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_abx <= n1_abx; r1_aby <= n1_aby;
            r1_bcx <= n1_bcx; r1_bcy <= n1_bcy;
            r1_ax2 <= n1_ax2; r1_ay2 <= n1_ay2;
            r1_bx2 <= n1_bx2; r1_by2 <= n1_by2;
            r1_cx2 <= n1_cx2; r1_cy2 <= n1_cy2;
            r1_ax  <= i_point_a_x;
            r1_ay  <= i_point_a_y;
        end
    end

    // stage 2: determinant products, A2 and B2
    logic signed [PW-1:0]  r2_p1, r2_p2, r2_a2, r2_b2;
    logic signed [DFW-1:0] r2_abx, r2_aby, r2_bcx, r2_bcy;
    logic [W-1:0]          r2_ax, r2_ay;
    logic signed [PW-1:0]  n2_p1, n2_p2, n2_a2, n2_b2;

    assign n2_p1 = r1_abx * r1_bcy;
    assign n2_p2 = r1_bcx * r1_aby;
    assign n2_a2 = PW'(r1_ax2) + PW'(r1_ay2) - PW'(r1_bx2) - PW'(r1_by2);
    assign n2_b2 = PW'(r1_bx2) + PW'(r1_by2) - PW'(r1_cx2) - PW'(r1_cy2);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_p1  <= n2_p1;  r2_p2  <= n2_p2;
            r2_a2  <= n2_a2;  r2_b2  <= n2_b2;
            r2_abx <= r1_abx; r2_aby <= r1_aby;
            r2_bcx <= r1_bcx; r2_bcy <= r1_bcy;
            r2_ax  <= r1_ax;  r2_ay  <= r1_ay;
        end
    end

    // stage 3: determinant and numerator products
    logic signed [DTW-1:0] r3_det;
    logic signed [MW-1:0]  r3_m1, r3_m2, r3_m3, r3_m4;
    logic [W-1:0]          r3_ax, r3_ay;
    logic signed [DTW-1:0] n3_det;
    logic signed [MW-1:0]  n3_m1, n3_m2, n3_m3, n3_m4;

    assign n3_det = DTW'(r2_p1) - DTW'(r2_p2);
    assign n3_m1  = r2_a2 * r2_bcy;
    assign n3_m2  = r2_b2 * r2_aby;
    assign n3_m3  = r2_abx * r2_b2;
    assign n3_m4  = r2_bcx * r2_a2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_det <= n3_det;
            r3_m1  <= n3_m1; r3_m2 <= n3_m2;
            r3_m3  <= n3_m3; r3_m4 <= n3_m4;
            r3_ax  <= r2_ax; r3_ay <= r2_ay;
        end
    end

    // stage 4: numerators, |det| and the collinearity test
    logic signed [NW-1:0]  r4_nx, r4_ny;
    logic [ABW-1:0]        r4_absdet;
    logic                  r4_detn, r4_ok;
    logic [W-1:0]          r4_ax, r4_ay;
    logic signed [NW-1:0]  n4_nx, n4_ny;
    logic [DTW-1:0]        n4_mag;
    logic [ABW-1:0]        n4_absdet;
    logic                  n4_ok;

    assign n4_nx     = NW'(r3_m1) - NW'(r3_m2);
    assign n4_ny     = NW'(r3_m3) - NW'(r3_m4);
    assign n4_mag    = r3_det[DTW-1] ? DTW'(-r3_det) : DTW'(r3_det);
    assign n4_absdet = n4_mag[ABW-1:0];
    assign n4_ok     = (n4_absdet != '0) && (CW'(n4_absdet) >= CW'(r_tol));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_nx     <= n4_nx;
            r4_ny     <= n4_ny;
            r4_absdet <= n4_absdet;
            r4_detn   <= r3_det[DTW-1];
            r4_ok     <= n4_ok;
            r4_ax     <= r3_ax;
            r4_ay     <= r3_ay;
        end
    end

    // divider entry: magnitudes, quotient signs and divisor
    t_div           r_dv [0:NW];
    t_div           n_dv0;
    logic [NW-1:0]  n_nxm, n_nym;

    assign n_nxm = r4_nx[NW-1] ? NW'(-r4_nx) : NW'(r4_nx);
    assign n_nym = r4_ny[NW-1] ? NW'(-r4_ny) : NW'(r4_ny);

    always_comb begin
        n_dv0.ok  = r4_ok;
        n_dv0.qxn = r4_nx[NW-1] ^ r4_detn;
        n_dv0.qyn = r4_ny[NW-1] ^ r4_detn;
        n_dv0.ax  = r4_ax;
        n_dv0.ay  = r4_ay;
        n_dv0.den = {r4_absdet, 1'b0};
        n_dv0.rx  = {{DNW{1'b0}}, n_nxm};
        n_dv0.ry  = {{DNW{1'b0}}, n_nym};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0] <= n_dv0;
        end
    end

    // restoring division, one quotient bit per stage for both axes
    for (genvar k = 0; k < NW; k++) begin : g_div
        logic [DNW:0]  tx, ty;
        logic          gx, gy;
        logic [DNW:0]  sx, sy;
        t_div          n_dv;

        always_comb begin
            tx = r_dv[k].rx[DNW+NW-1:NW-1];
            ty = r_dv[k].ry[DNW+NW-1:NW-1];
            gx = tx >= {1'b0, r_dv[k].den};
            gy = ty >= {1'b0, r_dv[k].den};
            sx = gx ? tx - {1'b0, r_dv[k].den} : tx;
            sy = gy ? ty - {1'b0, r_dv[k].den} : ty;
            n_dv    = r_dv[k];
            n_dv.rx = {sx[DNW-1:0], r_dv[k].rx[NW-2:0], gx};
            n_dv.ry = {sy[DNW-1:0], r_dv[k].ry[NW-2:0], gy};
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[k+1] <= n_dv;
            end
        end
    end

    // post A: clip the centre, form differences to point a
    logic [QXW-1:0]        pa_qx, pa_qy;
    logic [CTW-1:0]        pa_cx, pa_cy;
    logic                  pa_satx, pa_saty, pa_bigx, pa_bigy;
    logic [XW-1:0]         pa_sqx, pa_sqy;
    logic signed [XW-1:0]  pa_dx, pa_dy;
    logic [CTW-1:0]        ra_cx, ra_cy;
    logic                  ra_ok, ra_sat, ra_big;
    logic signed [XW-1:0]  ra_dx, ra_dy;

    assign pa_qx = QXW'(r_dv[NW].rx[NW-1:0]);
    assign pa_qy = QXW'(r_dv[NW].ry[NW-1:0]);

    always_comb begin
        if (r_dv[NW].qxn) begin
            pa_satx = (pa_qx[QXW-1:CTW] != '0) || (pa_qx[CTW-1] && (pa_qx[CTW-2:0] != '0));
            pa_cx   = pa_satx ? {1'b1, {(CTW-1){1'b0}}} : CTW'(-pa_qx[CTW-1:0]);
        end else begin
            pa_satx = pa_qx[QXW-1:CTW-1] != '0;
            pa_cx   = pa_satx ? {1'b0, {(CTW-1){1'b1}}} : pa_qx[CTW-1:0];
        end
        if (r_dv[NW].qyn) begin
            pa_saty = (pa_qy[QXW-1:CTW] != '0) || (pa_qy[CTW-1] && (pa_qy[CTW-2:0] != '0));
            pa_cy   = pa_saty ? {1'b1, {(CTW-1){1'b0}}} : CTW'(-pa_qy[CTW-1:0]);
        end else begin
            pa_saty = pa_qy[QXW-1:CTW-1] != '0;
            pa_cy   = pa_saty ? {1'b0, {(CTW-1){1'b1}}} : pa_qy[CTW-1:0];
        end
        pa_bigx = pa_qx[QXW-1:circ_pkg::SMALL_BITS] != '0;
        pa_bigy = pa_qy[QXW-1:circ_pkg::SMALL_BITS] != '0;
        pa_sqx  = XW'(pa_qx[circ_pkg::SMALL_BITS-1:0]);
        pa_sqy  = XW'(pa_qy[circ_pkg::SMALL_BITS-1:0]);
        if (r_dv[NW].qxn) begin
            pa_sqx = -pa_sqx;
        end
        if (r_dv[NW].qyn) begin
            pa_sqy = -pa_sqy;
        end
        pa_dx = $signed({{(XW-W){r_dv[NW].ax[W-1]}}, r_dv[NW].ax}) - $signed(pa_sqx);
        pa_dy = $signed({{(XW-W){r_dv[NW].ay[W-1]}}, r_dv[NW].ay}) - $signed(pa_sqy);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            ra_ok  <= r_dv[NW].ok;
            ra_sat <= pa_satx | pa_saty;
            ra_big <= pa_bigx | pa_bigy;
            ra_cx  <= pa_cx;
            ra_cy  <= pa_cy;
            ra_dx  <= pa_dx;
            ra_dy  <= pa_dy;
        end
    end

    // post B: difference magnitudes and range check
    logic [XW-1:0]                   pb_mx, pb_my;
    logic [circ_pkg::DIFF_BITS-1:0]  rb_mx, rb_my;
    logic [CTW-1:0]                  rb_cx, rb_cy;
    logic                            rb_ok, rb_sat, rb_big;

    assign pb_mx = ra_dx[XW-1] ? XW'(-ra_dx) : XW'(ra_dx);
    assign pb_my = ra_dy[XW-1] ? XW'(-ra_dy) : XW'(ra_dy);

    always_ff @(posedge i_clk) begin
        if (en) begin
            rb_ok  <= ra_ok;
            rb_sat <= ra_sat;
            rb_big <= ra_big || (pb_mx[XW-1:circ_pkg::DIFF_BITS] != '0)
                             || (pb_my[XW-1:circ_pkg::DIFF_BITS] != '0);
            rb_mx  <= pb_mx[circ_pkg::DIFF_BITS-1:0];
            rb_my  <= pb_my[circ_pkg::DIFF_BITS-1:0];
            rb_cx  <= ra_cx;
            rb_cy  <= ra_cy;
        end
    end

    // post C: squared differences
    logic [63:0]     rc_sx, rc_sy;
    logic [CTW-1:0]  rc_cx, rc_cy;
    logic            rc_ok, rc_sat, rc_big;

    always_ff @(posedge i_clk) begin
        if (en) begin
            rc_sx  <= 64'(rb_mx) * 64'(rb_mx);
            rc_sy  <= 64'(rb_my) * 64'(rb_my);
            rc_ok  <= rb_ok;
            rc_sat <= rb_sat;
            rc_big <= rb_big;
            rc_cx  <= rb_cx;
            rc_cy  <= rb_cy;
        end
    end

    // root entry: squared radius with clipping
    t_root                          r_rt [0:RS];
    t_root                          n_rt0;
    logic [circ_pkg::RSQ_SUM_W-1:0] pd_sum;
    logic                           pd_fit;

    assign pd_sum = circ_pkg::RSQ_SUM_W'(rc_sx) + circ_pkg::RSQ_SUM_W'(rc_sy);
    assign pd_fit = !rc_big && (pd_sum[circ_pkg::RSQ_SUM_W-1:RQW] == '0);

    always_comb begin
        n_rt0.ok  = rc_ok;
        n_rt0.sat = rc_sat | !pd_fit;
        n_rt0.cx  = rc_cx;
        n_rt0.cy  = rc_cy;
        n_rt0.rsq = pd_fit ? pd_sum[RQW-1:0] : {RQW{1'b1}};
        n_rt0.rem = 64'(n_rt0.rsq);
        n_rt0.res = '0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rt[0] <= n_rt0;
        end
    end

    // integer square root, one result bit per stage
    for (genvar k = 0; k < RS; k++) begin : g_root
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;
        t_root       n_rt;

        always_comb begin
            trial = r_rt[k].res + BIT;
            n_rt  = r_rt[k];
            if (r_rt[k].rem >= trial) begin
                n_rt.rem = r_rt[k].rem - trial;
                n_rt.res = (r_rt[k].res >> 1) + BIT;
            end else begin
                n_rt.res = r_rt[k].res >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rt[k+1] <= n_rt;
            end
        end
    end

    // output register, zeros for collinear points
    logic                          r_ok, r_sat;
    logic [CTW-1:0]                r_cx, r_cy;
    logic [RQW-1:0]                r_rsq;
    logic [circ_pkg::RLEN_WIDTH-1:0] r_rlen;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ok   <= r_rt[RS].ok;
            r_sat  <= r_rt[RS].ok & r_rt[RS].sat;
            r_cx   <= r_rt[RS].ok ? r_rt[RS].cx : '0;
            r_cy   <= r_rt[RS].ok ? r_rt[RS].cy : '0;
            r_rsq  <= r_rt[RS].ok ? r_rt[RS].rsq : '0;
            r_rlen <= r_rt[RS].ok ? r_rt[RS].res[circ_pkg::RLEN_WIDTH-1:0] : '0;
        end
    end

    assign o_ok             = r_ok;
    assign o_saturated      = r_sat;
    assign o_centre_x       = r_cx;
    assign o_centre_y       = r_cy;
    assign o_radius_squared = r_rsq;
    assign o_radius_length  = r_rlen;

endmodule
